@@ rtl/core/hsvrgb_pkg.sv @@
`default_nettype none

package hsvrgb_pkg;

    // Default widths of the color components and of the hue fraction.
    localparam int COLOR_BITS_DEF    = 8;
    localparam int HUE_FRAC_BITS_DEF = 6;

    // One sector spans 60 degrees, the full circle holds six of them.
    localparam int SECTOR_DEGREES = 60;
    localparam int NUM_SECTORS    = 6;

    // Register stages between the input and the output word.
    localparam int NUM_STAGES = 5;

    // Hue sectors, named by the two primaries or secondaries they span.
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

endpackage

`default_nettype wire

@@ rtl/core/hsvrgb_fulldiv.sv @@
`default_nettype none

// Rounded division of a product of two components by full scale (2^n - 1).
// The quotient estimate from one shift-and-add is at most one too small,
// so a single compare of the remainder completes it.
module hsvrgb_fulldiv
    import hsvrgb_pkg::*;
#(
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  wire logic [2*COLOR_BITS-1:0] i_prod,
    output logic      [COLOR_BITS-1:0]   o_quot
);

    localparam int PW = 2 * COLOR_BITS;
    localparam logic [PW+1:0] FULL = (PW+2)'((1 << COLOR_BITS) - 1);
    localparam logic [PW+1:0] HALF = FULL >> 1;

    logic [PW+1:0]       y;
    logic [PW+1:0]       sum;
    logic [COLOR_BITS:0] q0;
    logic [PW+1:0]       q0_full;
    logic [PW+1:0]       rem;

    always_comb begin
        // Add half of full scale so that the floor rounds half up.
        y       = (PW+2)'(i_prod) + HALF;
        sum     = y + (y >> COLOR_BITS);
        q0      = (COLOR_BITS+1)'(sum >> COLOR_BITS);
        // q0 times full scale is q0 shifted up minus q0 itself.
        q0_full = ((PW+2)'(q0) << COLOR_BITS) - (PW+2)'(q0);
        rem     = y - q0_full;
        if (rem >= FULL) begin
            o_quot = COLOR_BITS'(q0 + 1'b1);
        end else begin
            o_quot = COLOR_BITS'(q0);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/hsv_to_rgb_converter.sv @@
// HSV to RGB color converter.
//
// Input stream (s side): one word per color, tdata holds hue, saturation
// and brightness. Hue counts in steps of 2^-HUE_FRAC_BITS degree; codes at
// or past 360 degrees wrap around the circle. Saturation and brightness use
// COLOR_BITS bits with all ones standing for 1.0.
// Output stream (m side): one word per input word, tdata holds red, green
// and blue at COLOR_BITS bits each, in the same order as the input.
//
// The datapath is a five-stage pipeline: hue wrap and value times
// saturation, chroma rounding and sector split, chroma times fraction,
// division by the sector length, then placement and offset. One word is
// accepted in every cycle unless a receiver stall has filled the pipeline,
// limited only by the slowest stage; no stage holds more than one multiplier.
//
// Reset empties the pipeline. When the receiver stalls, each stage holds
// its word while every later stage is full, and empty stages keep filling, so
// up to five words are buffered before s_tready drops. Nothing is lost or
// repeated.
`default_nettype none

module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
#(
    parameter int COLOR_BITS    = COLOR_BITS_DEF,
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
    localparam int HW     = 9 + HUE_FRAC_BITS,
    localparam int IN_W   = HW + 2 * COLOR_BITS,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = 3 * COLOR_BITS,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0 up: hue, saturation, brightness, zero padding.
    input  wire logic [IN_TW-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // Fields from bit 0 up: red, green, blue, zero padding.
    output logic      [OUT_TW-1:0] m_tdata
);

    localparam int CB         = COLOR_BITS;
    localparam int SW         = 6 + HUE_FRAC_BITS;
    localparam int SECTOR_LEN = SECTOR_DEGREES << HUE_FRAC_BITS;
    localparam int CIRCLE_LEN = SECTOR_LEN * NUM_SECTORS;
    localparam int PW3        = CB + SW;
    // The sector length is 15 times a power of two: shift, then divide by 15.
    localparam int SHIFT15    = HUE_FRAC_BITS + 2;
    localparam int ZW         = CB + 4;
    localparam int K15        = ZW + 4;
    localparam int RW         = K15 - 3;
    localparam logic [RW-1:0] RECIP15 = RW'(((longint'(1)) << K15) / 15 + 1);
    localparam int MW         = ZW + RW;

    // Stage valid bits and stage enables.
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_en;

    always_comb begin
        n_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    assign s_tready = n_en[0];
    assign m_tvalid = r_vld[NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: wrap the hue into one circle and multiply value by saturation.
    logic [HW-1:0]   in_hue;
    logic [CB-1:0]   in_sat;
    logic [CB-1:0]   in_val;
    logic [HW-1:0]   n_hue_mod;
    logic [HW-1:0]   r1_hue;
    logic [2*CB-1:0] r1_prod;
    logic [CB-1:0]   r1_val;

    assign in_hue = s_tdata[HW-1:0];
    assign in_sat = s_tdata[HW+CB-1:HW];
    assign in_val = s_tdata[HW+2*CB-1:HW+CB];

    always_comb begin
        if (in_hue >= HW'(CIRCLE_LEN)) begin
            n_hue_mod = in_hue - HW'(CIRCLE_LEN);
        end else begin
            n_hue_mod = in_hue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r1_hue  <= n_hue_mod;
            r1_prod <= (2*CB)'(in_val) * (2*CB)'(in_sat);
            r1_val  <= in_val;
        end
    end

    // Stage 2: round the chroma and split the hue into sector and remainder.
    logic [CB-1:0] n_chroma;
    t_sector       n_sec;
    logic [SW-1:0] n_rem;
    logic [CB-1:0] r2_chroma;
    logic [CB-1:0] r2_val;
    t_sector       r2_sec;
    logic [SW-1:0] r2_rem;

    hsvrgb_fulldiv #(
        .COLOR_BITS(COLOR_BITS)
    ) u_fulldiv (
        .i_prod(r1_prod),
        .o_quot(n_chroma)
    );

    always_comb begin
        n_sec = SEC_RED_YEL;
        n_rem = SW'(r1_hue);
        for (int k = 1; k < NUM_SECTORS; k++) begin
            if (r1_hue >= HW'(k * SECTOR_LEN)) begin
                n_sec = t_sector'(3'(k));
                n_rem = SW'(r1_hue - HW'(k * SECTOR_LEN));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            r2_chroma <= n_chroma;
            r2_val    <= r1_val;
            r2_sec    <= n_sec;
            r2_rem    <= n_rem;
        end
    end

    // Stage 3: chroma times the rising or falling fraction of the sector.
    logic [SW-1:0]  n_frac;
    logic [PW3-1:0] r3_prod;
    logic [CB-1:0]  r3_chroma;
    logic [CB-1:0]  r3_offs;
    t_sector        r3_sec;

    always_comb begin
        if (r2_sec[0]) begin
            n_frac = SW'(SECTOR_LEN) - r2_rem;
        end else begin
            n_frac = r2_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[2]) begin
            r3_prod   <= PW3'(r2_chroma) * PW3'(n_frac);
            r3_chroma <= r2_chroma;
            r3_offs   <= r2_val - r2_chroma;
            r3_sec    <= r2_sec;
        end
    end

    // Stage 4: rounded division by the sector length.
    logic [PW3-1:0] n_round;
    logic [ZW-1:0]  n_z;
    logic [MW-1:0]  n_recip_prod;
    logic [CB-1:0]  r4_xs;
    logic [CB-1:0]  r4_chroma;
    logic [CB-1:0]  r4_offs;
    t_sector        r4_sec;

    always_comb begin
        n_round      = r3_prod + PW3'(SECTOR_LEN / 2);
        n_z          = ZW'(n_round >> SHIFT15);
        n_recip_prod = MW'(n_z) * MW'(RECIP15);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[3]) begin
            r4_xs     <= CB'(n_recip_prod >> K15);
            r4_chroma <= r3_chroma;
            r4_offs   <= r3_offs;
            r4_sec    <= r3_sec;
        end
    end

    // Stage 5: place chroma and secondary by sector and add the offset.
    logic [CB-1:0] n_red;
    logic [CB-1:0] n_green;
    logic [CB-1:0] n_blue;
    logic [CB-1:0] r5_red;
    logic [CB-1:0] r5_green;
    logic [CB-1:0] r5_blue;

    always_comb begin
        unique case (r4_sec)
            SEC_RED_YEL: begin
                n_red = r4_chroma; n_green = r4_xs;     n_blue = '0;
            end
            SEC_YEL_GRN: begin
                n_red = r4_xs;     n_green = r4_chroma; n_blue = '0;
            end
            SEC_GRN_CYN: begin
                n_red = '0;        n_green = r4_chroma; n_blue = r4_xs;
            end
            SEC_CYN_BLU: begin
                n_red = '0;        n_green = r4_xs;     n_blue = r4_chroma;
            end
            SEC_BLU_MAG: begin
                n_red = r4_xs;     n_green = '0;        n_blue = r4_chroma;
            end
            default: begin
                n_red = r4_chroma; n_green = '0;        n_blue = r4_xs;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_en[4]) begin
            r5_red   <= n_red + r4_offs;
            r5_green <= n_green + r4_offs;
            r5_blue  <= n_blue + r4_offs;
        end
    end

    assign m_tdata = OUT_TW'({r5_blue, r5_green, r5_red});

endmodule

`default_nettype wire

@@ tb/hsv_to_rgb_converter_test.sv @@
`timescale 1ns / 100ps

module hsv_to_rgb_converter_test
    import hsvrgb_pkg::*;
;

    localparam int HUE_W      = 9 + HUE_FRAC_BITS_DEF;
    localparam int CB         = COLOR_BITS_DEF;
    localparam int FULL       = (1 << CB) - 1;
    localparam int SECTOR_LEN = SECTOR_DEGREES << HUE_FRAC_BITS_DEF;
    localparam int CIRCLE_LEN = SECTOR_LEN * NUM_SECTORS;
    localparam int IN_TW      = ((HUE_W + 2 * CB + 7) / 8) * 8;
    localparam int OUT_TW     = ((3 * CB + 7) / 8) * 8;
    localparam int RANDOM_WORDS = 1750;
    // No idling once this few words are left to send.
    localparam int CALM_TAIL  = 250;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4 * NUM_STAGES;

    typedef struct packed {
        logic [CB-1:0] blue;
        logic [CB-1:0] green;
        logic [CB-1:0] red;
    } t_rgb;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // Fields from bit 0 up: hue, saturation, brightness, zero padding.
    logic [IN_TW-1:0]  s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // Fields from bit 0 up: red, green, blue, zero padding.
    logic [OUT_TW-1:0] m_tdata;

    logic [IN_TW-1:0] pending_words[$];
    t_rgb             rgb_expected[$];
    logic             in_accepted = 1'b0;
    logic             jitter_on = 1'b1;
    int               send_gap = 0;
    int               stall_left = 0;
    int               mismatch_count = 0;
    int               cycle_count = 0;

    hsv_to_rgb_converter u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Computes the color that one hue, saturation and brightness word turns into.
    function automatic t_rgb hsv_to_rgb_predict(logic [HUE_W-1:0] hue, logic [CB-1:0] sat,
                                                logic [CB-1:0] val);
        int unsigned h, s, v, chroma, rem, xs, offs;
        t_sector     sec;
        t_rgb        color;
        h      = int'(hue) % CIRCLE_LEN;
        s      = sat;
        v      = val;
        chroma = (v * s + FULL / 2) / FULL;
        sec    = t_sector'(h / SECTOR_LEN);
        rem    = h % SECTOR_LEN;
        // Rising edge of the secondary in even sectors, falling edge in odd ones.
        if (sec[0] == 1'b0) begin
            xs = (chroma * rem + SECTOR_LEN / 2) / SECTOR_LEN;
        end else begin
            xs = (chroma * (SECTOR_LEN - rem) + SECTOR_LEN / 2) / SECTOR_LEN;
        end
        offs = v - chroma;
        case (sec)
            SEC_RED_YEL: begin
                color.red = CB'(chroma + offs); color.green = CB'(xs + offs);
                color.blue = CB'(offs);
            end
            SEC_YEL_GRN: begin
                color.red = CB'(xs + offs); color.green = CB'(chroma + offs);
                color.blue = CB'(offs);
            end
            SEC_GRN_CYN: begin
                color.red = CB'(offs); color.green = CB'(chroma + offs);
                color.blue = CB'(xs + offs);
            end
            SEC_CYN_BLU: begin
                color.red = CB'(offs); color.green = CB'(xs + offs);
                color.blue = CB'(chroma + offs);
            end
            SEC_BLU_MAG: begin
                color.red = CB'(xs + offs); color.green = CB'(offs);
                color.blue = CB'(chroma + offs);
            end
            default: begin
                color.red = CB'(chroma + offs); color.green = CB'(offs);
                color.blue = CB'(xs + offs);
            end
        endcase
        return color;
    endfunction

    task automatic add_color(int unsigned hue, int unsigned sat, int unsigned val);
        logic [IN_TW-1:0] word;
        word = '0;
        word[HUE_W-1:0]              = hue[HUE_W-1:0];
        word[HUE_W+CB-1:HUE_W]       = sat[CB-1:0];
        word[HUE_W+2*CB-1:HUE_W+CB]  = val[CB-1:0];
        pending_words.push_back(word);
    endtask

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
        mismatch_count++;
    endtask

    function automatic int unsigned pick_level();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return FULL;
        return $urandom_range(0, FULL);
    endfunction

    // Input side: present the next word once the current one has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_accepted) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_tdata  <= pending_words.pop_front();
                s_tvalid <= 1'b1;
                if (jitter_on && pending_words.size() > CALM_TAIL &&
                    $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(1, 11);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random stall bursts on the receiver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (jitter_on && pending_words.size() > CALM_TAIL &&
                $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(1, 11);
            end
        end
    end

    // Check each output word against the oldest prediction, then predict
    // from the input word taken at this edge.
    always @(posedge i_clk) begin
        t_rgb want;
        t_rgb got;
        cycle_count <= cycle_count + 1;
        in_accepted <= s_tvalid && s_tready;
        if ($urandom_range(0, 63) == 0) begin
            jitter_on <= ~jitter_on;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[3*CB-1:0];
            if (rgb_expected.size() == 0) begin
                report_mismatch("unexpected word, red", 0, got.red);
            end else begin
                want = rgb_expected.pop_front();
                if (got.red !== want.red) report_mismatch("red", want.red, got.red);
                if (got.green !== want.green) report_mismatch("green", want.green, got.green);
                if (got.blue !== want.blue) report_mismatch("blue", want.blue, got.blue);
            end
        end
        if (i_rst_n && s_tvalid && s_tready) begin
            rgb_expected.push_back(hsv_to_rgb_predict(s_tdata[HUE_W-1:0],
                                                      s_tdata[HUE_W+CB-1:HUE_W],
                                                      s_tdata[HUE_W+2*CB-1:HUE_W+CB]));
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned roll;
        int unsigned hue;
        // Hue extremes, including codes at and past the full circle.
        add_color(0, FULL, FULL);
        add_color(CIRCLE_LEN - 1, FULL, FULL);
        add_color(CIRCLE_LEN, FULL, FULL);
        add_color((1 << HUE_W) - 1, FULL, FULL);
        // Both sides of every inner sector boundary, and the middle of each sector.
        for (int k = 1; k < NUM_SECTORS; k++) begin
            add_color(k * SECTOR_LEN - 1, FULL, FULL);
            add_color(k * SECTOR_LEN, 200, 180);
        end
        for (int k = 0; k < NUM_SECTORS; k++) begin
            add_color(k * SECTOR_LEN + SECTOR_LEN / 2, 128, FULL);
        end
        // Grey: zero saturation or zero brightness.
        add_color(5000, 0, 177);
        add_color(12000, FULL, 0);
        add_color(0, 0, 0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) hue = $urandom_range(CIRCLE_LEN, (1 << HUE_W) - 1);
            else if (roll == 1) hue = $urandom & ((1 << HUE_W) - 1);
            else hue = $urandom_range(0, CIRCLE_LEN - 1);
            add_color(hue, pick_level(), pick_level());
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait for every word to be sent and every prediction to be met.
        @(negedge i_clk);
        while (pending_words.size() != 0 || s_tvalid || rgb_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && rgb_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
